@@ rtl/core/gtp_pkg.sv @@
// Shared types and constants for the galvo trapezoid profile unit.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package gtp_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // phase codes
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_AXIS_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TICK_PERIOD = 2'd1;
  localparam logic [1:0] CFG_FS_WIDTH    = 2'd2;

  localparam logic [1:0]  AXIS_ENABLE_RST = 2'd3;
  localparam logic [31:0] TICK_PERIOD_RST = 32'd42950;
  localparam logic [9:0]  FS_WIDTH_RST    = 10'd200;

  localparam int MUL_W = 64;   // serial multiplier operand width
  localparam int DIV_W = 32;   // divider dividend width
  localparam int DEN_W = 11;   // divider divisor width

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/gtp_mul.sv @@
// Shift-add serial multiplier, 64x64 unsigned to 128-bit product, one bit a cycle.
// Depends on gtp_pkg.
`default_nettype none
module gtp_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gtp_pkg::MUL_W-1:0]     a_i,
  input  wire logic [gtp_pkg::MUL_W-1:0]     b_i,
  output gtp_pkg::unit_stat_t                stat_o,
  output logic      [2*gtp_pkg::MUL_W-1:0]   prod_o
);
  import gtp_pkg::*;

  localparam int CntW = $clog2(MUL_W + 1);

  logic [MUL_W-1:0] a_q, hi_q, lo_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MUL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[MUL_W:1];
      lo_q <= {sum[0], lo_q[MUL_W-1:1]};
    end
  end

  assign prod_o      = {hi_q, lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

@@ rtl/core/gtp_div.sv @@
// Restoring serial divider, 32-bit dividend by 11-bit divisor, one bit a cycle.
// Depends on gtp_pkg.
`default_nettype none
module gtp_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [gtp_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [gtp_pkg::DEN_W-1:0]   divisor_i,
  output gtp_pkg::unit_stat_t              stat_o,
  output logic      [gtp_pkg::DIV_W-1:0]   quotient_o
);
  import gtp_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so DEN_W bits hold it
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

@@ rtl/core/galvo_trapezoid_profile_unit.sv @@
// Top level of the galvo trapezoid profile unit: sequencer, per-axis state, I/O.
// Depends on gtp_pkg, gtp_mul and gtp_div.
//
// Usage:
//  - Input words arrive on s_axis_*: tuser carries operation, axis and phase,
//    tdata carries ticks, move parameters and the cruise/decel empty flags.
//  - Every input word yields exactly one output word on m_axis_*: tuser holds
//    the axis and the applied flag, tdata the position and channel value.
//  - Configuration goes through cfg_we_i / cfg_index_i / cfg_data_i while idle.
//  - One word is processed at a time; s_axis_tready_o is high only when the
//    sequencer is idle. All products go through one 64x64 shift-add
//    multiplier, each product taking a start, 64 steps and a handoff; the
//    channel value goes through a 32-step divider.
//  - Path, acceptance to tvalid: load, phase start, cruise/decel phase-done
//    and ignored words go through the apply step, the divider and handoff;
//    an ignored tick or accel phase-done first passes ST_MT. An applied accel
//    phase-done or cruise tick adds two products; an applied accel or decel
//    tick adds four. The next word is taken when tvalid rises.
//  - A finished result sits in the output register; the next input word is
//    taken while it waits. If the receiver stalls, the sequencer holds in
//    its final step until the output register frees up.
//  - Reset clears all per-axis state to zero and loads the register defaults
//    (both axes enabled, tick period 42950, width 200 mm).
`default_nettype none
module galvo_trapezoid_profile_unit #(
  parameter int NUM_AXES = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // ticks[23:0] move_accel[55:24] entry_velocity[87:56] start_pos[119:88]
  // distance[151:120] cruise_empty[152] decel_empty[153] zero[159:154]
  input  wire logic [159:0] s_axis_tdata_i,
  // operation[1:0] axis[2] phase[4:3]
  input  wire logic [4:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_position[31:0] chan_code[47:32]
  output logic [47:0]       m_axis_tdata_o,
  // out_axis[0] out_valid[1]
  output logic [1:0]        m_axis_tuser_o,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  import gtp_pkg::*;

  localparam int IdxW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MT    = 3'd1;  // t = ticks * period
  localparam logic [2:0] ST_MV    = 3'd2;  // rate * t
  localparam logic [2:0] ST_MH    = 3'd3;  // t^2 / 2
  localparam logic [2:0] ST_MA    = 3'd4;  // accel * t^2 / 2
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // config
  logic [1:0]  axis_en_q;
  logic [31:0] tick_period_q;
  logic [9:0]  fs_width_q;

  // per-axis state
  logic [31:0] cur_pos_q   [NUM_AXES];
  logic [31:0] ps_pos_q    [NUM_AXES];
  logic [31:0] cur_vel_q   [NUM_AXES];
  logic [31:0] ps_vel_q    [NUM_AXES];
  logic [31:0] accel_q     [NUM_AXES];
  logic [31:0] target_q    [NUM_AXES];
  logic        active_q    [NUM_AXES];

  // latched item
  logic [1:0]  op_q, ph_q;
  logic        ax_q, ce_q, de_q;
  logic [23:0] ticks_q;
  logic [31:0] in_accel_q, in_vel_q, in_start_q, in_dist_q;

  logic [2:0]  state_q;
  logic        go_q;
  logic [55:0] t_q;
  logic [63:0] half_q;
  logic [31:0] rv_q, ha_q, pos_q;
  logic        applied_q, neg_q;
  logic [15:0] ch_q;

  logic        out_vld_q, out_axis_q, out_app_q;
  logic [31:0] out_pos_q;
  logic [15:0] out_ch_q;

  logic        in_acc, out_free;
  logic [IdxW-1:0] idx;
  logic        in_range_in, enabled, applies;

  // unit hookup
  logic            mul_start, div_start;
  logic [63:0]     mul_a, mul_b;
  logic [127:0]    mul_prod;
  unit_stat_t      mul_stat, div_stat;
  logic [31:0]     div_quo, div_mag;
  logic [10:0]     div_den;
  logic [31:0]     rate_sel;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign in_range_in = {31'd0, s_axis_tuser_i[2]} < 32'(NUM_AXES);
  assign idx         = IdxW'(ax_q);
  assign enabled     = axis_en_q[ax_q];
  assign applies     = enabled && active_q[idx] && (ph_q != 2'd3);

  // operand selection for the shared multiplier
  always_comb begin
    if (op_q == OP_DONE)             rate_sel = accel_q[idx];
    else if (ph_q == PH_ACCEL)       rate_sel = ps_vel_q[idx];
    else                             rate_sel = cur_vel_q[idx];
    unique case (state_q)
      ST_MT: begin
        mul_a = {32'd0, tick_period_q};
        mul_b = {40'd0, ticks_q};
      end
      ST_MV: begin
        mul_a = {{32{rate_sel[31]}}, rate_sel};
        mul_b = {8'd0, t_q};
      end
      ST_MH: begin
        mul_a = {8'd0, t_q};
        mul_b = {8'd0, t_q};
      end
      ST_MA: begin
        mul_a = {{32{accel_q[idx][31]}}, accel_q[idx]};
        mul_b = half_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // an item that does not apply skips the products altogether
  assign mul_start = !go_q && (((state_q == ST_MT) && applies) || (state_q == ST_MV)
                    || (state_q == ST_MH) || (state_q == ST_MA));

  gtp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  // new per-axis values, from latched item and products
  logic [31:0] new_pos;
  logic        snap;
  always_comb begin
    snap    = 1'b0;
    new_pos = cur_pos_q[idx];
    if (op_q == OP_LOAD) begin
      if (enabled && in_dist_q != 32'd0) new_pos = in_start_q;
    end else if (applies) begin
      if (op_q == OP_TICK) begin
        unique case (ph_q)
          PH_ACCEL:  new_pos = ps_pos_q[idx] + rv_q + ha_q;
          PH_CRUISE: new_pos = ps_pos_q[idx] + rv_q;
          default:   new_pos = ps_pos_q[idx] + rv_q - ha_q;
        endcase
      end else if (op_q == OP_DONE) begin
        unique case (ph_q)
          PH_ACCEL:  snap = ce_q && de_q;
          PH_CRUISE: snap = de_q;
          default:   snap = 1'b1;
        endcase
        if (snap) new_pos = target_q[idx];
      end
    end
  end

  // channel divider: |pos| / (2 * width)
  assign div_start = (state_q == ST_APPLY);
  assign div_mag   = new_pos[31] ? (32'd0 - new_pos) : new_pos;
  assign div_den   = {((fs_width_q == 10'd0) ? 10'd1 : fs_width_q), 1'b0};

  gtp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // saturate to Q1.15
  logic [16:0] q_sat;
  logic [15:0] ch_val;
  always_comb begin
    if (neg_q) q_sat = (div_quo > 32'd32768) ? 17'd32768 : div_quo[16:0];
    else       q_sat = (div_quo > 32'd32767) ? 17'd32767 : div_quo[16:0];
    ch_val = neg_q ? 16'(17'd0 - q_sat) : q_sat[15:0];
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_en_q     <= AXIS_ENABLE_RST;
      tick_period_q <= TICK_PERIOD_RST;
      fs_width_q    <= FS_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AXIS_ENABLE: axis_en_q     <= cfg_data_i[1:0];
        CFG_TICK_PERIOD: tick_period_q <= cfg_data_i;
        CFG_FS_WIDTH:    fs_width_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) out_vld_q <= 1'b1;
      else if (m_axis_tready_i)          out_vld_q <= 1'b0;
      if (mul_start) go_q <= 1'b1;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (!in_range_in) begin
              state_q <= ST_OUT;
            end else if (s_axis_tuser_i[1:0] == OP_TICK
                || (s_axis_tuser_i[1:0] == OP_DONE && s_axis_tuser_i[4:3] == PH_ACCEL)) begin
              state_q <= ST_MT;  // skipped below if the item does not apply
            end else begin
              state_q <= ST_APPLY;
            end
          end
        end
        ST_MT: begin
          if (!applies) state_q <= ST_APPLY;
          else if (mul_stat.done) begin
            go_q    <= 1'b0;
            state_q <= ST_MV;
          end
        end
        ST_MV: begin
          if (mul_stat.done) begin
            go_q    <= 1'b0;
            state_q <= (op_q == OP_TICK && ph_q != PH_CRUISE) ? ST_MH : ST_APPLY;
          end
        end
        ST_MH: begin
          if (mul_stat.done) begin
            go_q    <= 1'b0;
            state_q <= ST_MA;
          end
        end
        ST_MA: begin
          if (mul_stat.done) begin
            go_q    <= 1'b0;
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: state_q <= ST_DIV;
        ST_DIV:   if (div_stat.done) state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= s_axis_tuser_i[1:0];
      ax_q       <= s_axis_tuser_i[2];
      ph_q       <= s_axis_tuser_i[4:3];
      ticks_q    <= s_axis_tdata_i[23:0];
      in_accel_q <= s_axis_tdata_i[55:24];
      in_vel_q   <= s_axis_tdata_i[87:56];
      in_start_q <= s_axis_tdata_i[119:88];
      in_dist_q  <= s_axis_tdata_i[151:120];
      ce_q       <= s_axis_tdata_i[152];
      de_q       <= s_axis_tdata_i[153];
      // out-of-range axis reports zeros
      applied_q  <= 1'b0;
      pos_q      <= 32'd0;
      ch_q       <= 16'd0;
    end
    if (mul_stat.done) begin
      unique case (state_q)
        ST_MT:   t_q    <= mul_prod[55:0];
        ST_MV:   rv_q   <= mul_prod[63:32];
        ST_MH:   half_q <= mul_prod[96:33];
        ST_MA:   ha_q   <= mul_prod[62:31];
        default: ;
      endcase
    end
    if (state_q == ST_APPLY) begin
      pos_q     <= new_pos;
      neg_q     <= new_pos[31];
      applied_q <= (op_q == OP_LOAD) ? (enabled && in_dist_q != 32'd0) : applies;
    end
    if (state_q == ST_DIV && div_stat.done) ch_q <= ch_val;
    if (state_q == ST_OUT && out_free) begin
      out_axis_q <= ax_q;
      out_app_q  <= applied_q;
      out_pos_q  <= pos_q;
      out_ch_q   <= ch_q;
    end
  end

  // per-axis state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_pos_q[i] <= '0;
        ps_pos_q[i]  <= '0;
        cur_vel_q[i] <= '0;
        ps_vel_q[i]  <= '0;
        accel_q[i]   <= '0;
        target_q[i]  <= '0;
        active_q[i]  <= 1'b0;
      end
    end else if (state_q == ST_APPLY) begin
      cur_pos_q[idx] <= new_pos;
      if (op_q == OP_LOAD) begin
        if (enabled && in_dist_q != 32'd0) begin
          active_q[idx]  <= 1'b1;
          accel_q[idx]   <= in_accel_q;
          cur_vel_q[idx] <= in_vel_q;
          ps_vel_q[idx]  <= in_vel_q;
          ps_pos_q[idx]  <= in_start_q;
          target_q[idx]  <= in_start_q + in_dist_q;
        end else begin
          active_q[idx] <= 1'b0;
        end
      end else if (applies) begin
        if (op_q == OP_START) begin
          if (ph_q != PH_ACCEL) ps_pos_q[idx] <= cur_pos_q[idx];
          if (ph_q == PH_DECEL) ps_vel_q[idx] <= cur_vel_q[idx];
        end else if (op_q == OP_DONE && ph_q == PH_ACCEL) begin
          cur_vel_q[idx] <= ps_vel_q[idx] + rv_q;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_ch_q, out_pos_q};
  assign m_axis_tuser_o  = {out_app_q, out_axis_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("accepted word left no work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MA) |-> (op_q == OP_TICK && ph_q != PH_CRUISE))
    else $error("t^2 term computed for wrong item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !mul_stat.busy && !div_stat.busy)
    else $error("result issued while a unit still runs");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for galvo_trapezoid_profile_unit: directed and random
// load/phase/tick/done words against an in-bench profile predictor.
// Depends on gtp_pkg and the RTL under rtl/core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam int NAX = 2;
  localparam int LIMIT = 4_000_000;

  typedef struct packed {
    logic       axis;
    logic       applied;
    logic [31:0] pos;
    logic [15:0] chan;
  } prof_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;   // ticks, accel, vel, start, dist, cruise_empty, decel_empty
  logic [4:0] s_axis_tuser_i = '0;     // operation[1:0] axis[2] phase[4:3]
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;         // out_position[31:0] chan_code[47:32]
  logic [1:0] m_axis_tuser_o;          // out_axis[0] out_valid[1]
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  galvo_trapezoid_profile_unit #(.NUM_AXES(NAX)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [1:0]  en_mask;
  logic [31:0] tick_per;
  logic [9:0]  fs_width;
  logic [31:0] p_pos [NAX];
  logic [31:0] p_start_pos [NAX];
  logic [31:0] p_vel [NAX];
  logic [31:0] p_start_vel [NAX];
  logic [31:0] p_accel [NAX];
  logic [31:0] p_target [NAX];
  logic        p_active [NAX];

  prof_res_t expected_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int applied_seen = 0;
  longint cycles = 0;
  bit sink_idle_on = 1'b1;    // random stalls on the result side
  bit src_idle_on = 1'b1;
  int hold_off = 0;           // long receiver hold-off, in cycles

  // rate * t, Q16.16 x Q24.32 -> Q16.16, floor, wraps
  function automatic logic [31:0] scale_rate(logic [31:0] rate, logic [63:0] t);
    logic signed [127:0] p;
    p = $signed({{96{rate[31]}}, rate}) * $signed({64'd0, t});
    return p[63:32];
  endfunction

  // a * t^2 / 2
  function automatic logic [31:0] accel_term(logic [31:0] a, logic [63:0] t);
    logic [127:0] sq;
    logic [63:0]  half_sq;
    logic signed [127:0] p;
    sq = {64'd0, t} * {64'd0, t};
    half_sq = sq[96:33];
    p = $signed({{96{a[31]}}, a}) * $signed({64'd0, half_sq});
    return p[62:31];
  endfunction

  function automatic logic [15:0] chan_of(logic [31:0] pos);
    logic [63:0] den, mag, q;
    den = 2 * ((fs_width == 0) ? 64'd1 : 64'(fs_width));
    // magnitude taken at 32 bits, then widened
    mag = pos[31] ? {32'd0, 32'd0 - pos} : {32'd0, pos};
    if (pos[31] && mag == 0) mag = 64'h8000_0000;
    q = mag / den;
    if (pos[31]) begin
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic prof_res_t predict(logic [1:0] op, logic ax, logic [1:0] ph,
      logic [23:0] ticks, logic [31:0] a, logic [31:0] v, logic [31:0] s,
      logic [31:0] d, logic ce, logic de);
    prof_res_t r;
    logic ena;
    logic [63:0] t;
    ena = en_mask[ax];
    t = 64'(ticks) * 64'(tick_per);
    r.axis = ax;
    r.applied = 1'b0;
    if (op == OP_LOAD) begin
      if (ena && d != 0) begin
        p_active[ax] = 1'b1;
        p_accel[ax] = a;
        p_vel[ax] = v;
        p_start_vel[ax] = v;
        p_pos[ax] = s;
        p_start_pos[ax] = s;
        p_target[ax] = s + d;
        r.applied = 1'b1;
      end else begin
        p_active[ax] = 1'b0;
      end
    end else if (ena && p_active[ax] && ph <= PH_DECEL) begin
      r.applied = 1'b1;
      case (op)
        OP_START: begin
          if (ph != PH_ACCEL) p_start_pos[ax] = p_pos[ax];
          if (ph == PH_DECEL) p_start_vel[ax] = p_vel[ax];
        end
        OP_TICK: begin
          if (ph == PH_ACCEL)
            p_pos[ax] = p_start_pos[ax] + scale_rate(p_start_vel[ax], t)
                        + accel_term(p_accel[ax], t);
          else if (ph == PH_CRUISE)
            p_pos[ax] = p_start_pos[ax] + scale_rate(p_vel[ax], t);
          else
            p_pos[ax] = p_start_pos[ax] + scale_rate(p_vel[ax], t)
                        - accel_term(p_accel[ax], t);
        end
        default: begin
          if (ph == PH_ACCEL) begin
            p_vel[ax] = p_start_vel[ax] + scale_rate(p_accel[ax], t);
            if (ce && de) p_pos[ax] = p_target[ax];
          end else if (ph == PH_CRUISE) begin
            if (de) p_pos[ax] = p_target[ax];
          end else begin
            p_pos[ax] = p_target[ax];
          end
        end
      endcase
    end
    r.pos = p_pos[ax];
    r.chan = chan_of(p_pos[ax]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  // one word in, prediction queued at acceptance
  task automatic send_word(logic [1:0] op, logic ax, logic [1:0] ph, logic [23:0] ticks,
      logic [31:0] a = 0, logic [31:0] v = 0, logic [31:0] s = 0, logic [31:0] d = 0,
      logic ce = 0, logic de = 0);
    while (src_idle_on && $urandom_range(99) < 29) @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= {ph, ax, op};
    s_axis_tdata_i <= {6'd0, de, ce, d, s, v, a, ticks};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.push_back(predict(op, ax, ph, ticks, a, v, s, d, ce, de));
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // the block is busy with the accepted word anyway
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AXIS_ENABLE: en_mask = val[1:0];
      CFG_TICK_PERIOD: tick_per = val;
      default:         fs_width = val[9:0];
    endcase
  endtask

  // a well-formed move on one axis with random content
  task automatic run_move(logic ax, bit wide);
    logic [31:0] a, v, s, d;
    logic ce, de;
    int n;
    a = wide ? $urandom : 32'($signed($urandom_range(2000)) - 1000) <<< 16;
    v = wide ? $urandom : 32'($signed($urandom_range(400)) - 200) <<< 16;
    s = wide ? $urandom : 32'($signed($urandom_range(400)) - 200) <<< 16;
    d = ($urandom_range(15) == 0) ? 32'd0 : $urandom;
    ce = 1'($urandom_range(1));
    de = 1'($urandom_range(1));
    send_word(OP_LOAD, ax, PH_ACCEL, 24'($urandom), a, v, s, d, ce, de);
    for (int ph = 0; ph < 3; ph++) begin
      if ((ph == 1 && ce) || (ph == 2 && de)) continue;
      send_word(OP_START, ax, ph[1:0], 24'($urandom));
      n = $urandom_range(3);
      for (int k = 0; k < n; k++)
        send_word(OP_TICK, ax, ph[1:0], wide ? 24'($urandom) : 24'($urandom_range(5000)));
      send_word(OP_DONE, ax, ph[1:0], 24'($urandom_range(5000)), 0, 0, 0, 0, ce, de);
    end
  endtask

  task automatic random_noise();
    send_word(2'($urandom), 1'($urandom), 2'($urandom), 24'($urandom), $urandom, $urandom,
              $urandom, $urandom, 1'($urandom), 1'($urandom));
  endtask

  // --- test tasks ---
  task automatic test_directed();
    // field extremes on a load, then every op and phase, incl. phase code three
    send_word(OP_LOAD, 1'b0, PH_ACCEL, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(OP_TICK, 1'b0, PH_ACCEL, 24'hFFFFFF);
    send_word(OP_TICK, 1'b0, PH_DECEL, 24'd0);
    send_word(OP_START, 1'b0, 2'd3, 24'd5);
    send_word(OP_DONE, 1'b0, PH_ACCEL, 24'hFFFFFF, 0, 0, 0, 0, 1'b1, 1'b1);
    send_word(OP_LOAD, 1'b1, PH_ACCEL, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b1, PH_ACCEL, 24'd100);
    send_word(OP_DONE, 1'b1, PH_ACCEL, 24'd100);
    send_word(OP_START, 1'b1, PH_CRUISE, 24'd0);
    send_word(OP_TICK, 1'b1, PH_CRUISE, 24'd50);
    send_word(OP_DONE, 1'b1, PH_CRUISE, 24'd0, 0, 0, 0, 0, 1'b0, 1'b0);
    send_word(OP_START, 1'b1, PH_DECEL, 24'd0);
    send_word(OP_TICK, 1'b1, PH_DECEL, 24'd77);
    send_word(OP_DONE, 1'b1, PH_DECEL, 24'd0);
    // zero distance deactivates, items on inactive axis ignored
    send_word(OP_LOAD, 1'b1, PH_ACCEL, 24'd0, 1, 1, 32'h1234_0000, 32'd0);
    send_word(OP_TICK, 1'b1, PH_CRUISE, 24'd9);
    send_word(OP_LOAD, 1'b0, PH_ACCEL, 24'd0, 0, 0, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b1);
    send_word(OP_DONE, 1'b0, PH_CRUISE, 24'd0, 0, 0, 0, 0, 1'b0, 1'b1);
  endtask

  task automatic test_config_sweep();
    // disabled axis, min/max period, width 1 and 1000, zero width
    write_reg(CFG_AXIS_ENABLE, 32'd1);
    send_word(OP_LOAD, 1'b1, PH_ACCEL, 24'd0, 5, 5, 5, 5);
    send_word(OP_TICK, 1'b1, PH_ACCEL, 24'd3);
    run_move(1'b0, 1'b1);
    write_reg(CFG_AXIS_ENABLE, 32'd0);
    send_word(OP_TICK, 1'b0, PH_ACCEL, 24'd3);
    write_reg(CFG_AXIS_ENABLE, 32'd3);
    write_reg(CFG_TICK_PERIOD, 32'd1);
    write_reg(CFG_FS_WIDTH, 32'd1);
    run_move(1'b1, 1'b1);
    write_reg(CFG_TICK_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_FS_WIDTH, 32'd1000);
    run_move(1'b0, 1'b1);
    write_reg(CFG_FS_WIDTH, 32'd0);
    run_move(1'b1, 1'b0);
    write_reg(CFG_TICK_PERIOD, 32'd42950);
    write_reg(CFG_FS_WIDTH, 32'd200);
  endtask

  task automatic test_backpressure();
    // receiver holds off while sender keeps offering
    hold_off = 600;
    for (int i = 0; i < 6; i++) random_noise();
    // sender pauses until all results are in
    drain();
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    for (int i = 0; i < 40; i++) run_move(1'($urandom), 1'b0);
    sink_idle_on = 1'b1;
    src_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int phase_n;
    phase_n = 0;
    while (words_sent < 1100) begin
      if ($urandom_range(9) < 7) run_move(1'($urandom), $urandom_range(3) == 0);
      else random_noise();
      if (words_sent / 250 > phase_n) begin
        phase_n++;
        write_reg(CFG_AXIS_ENABLE, $urandom_range(3));
        write_reg(CFG_TICK_PERIOD, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000, 1));
        write_reg(CFG_FS_WIDTH, $urandom_range(1000, 1));
      end
    end
  endtask

  // result side: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(sink_idle_on && $urandom_range(99) < 29);
    end
  end

  // checker: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    prof_res_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata_o[31:0], 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser_o[0] !== want.axis)
          report_mismatch("out_axis", m_axis_tuser_o[0], want.axis);
        if (m_axis_tuser_o[1] !== want.applied)
          report_mismatch("out_valid", m_axis_tuser_o[1], want.applied);
        if (m_axis_tdata_o[31:0] !== want.pos)
          report_mismatch("out_position", m_axis_tdata_o[31:0], want.pos);
        if (m_axis_tdata_o[47:32] !== want.chan)
          report_mismatch("chan_code", m_axis_tdata_o[47:32], want.chan);
        applied_seen += want.applied;
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    en_mask = AXIS_ENABLE_RST;
    tick_per = TICK_PERIOD_RST;
    fs_width = FS_WIDTH_RST;
    for (int i = 0; i < NAX; i++) begin
      p_pos[i] = 0; p_start_pos[i] = 0; p_vel[i] = 0; p_start_vel[i] = 0;
      p_accel[i] = 0; p_target[i] = 0; p_active[i] = 0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    $display("Ran %0d words (%0d applied) over all ops, phases and register extremes,",
             words_sent, applied_seen);
    $display("with random stalls, a long output hold-off and %0d mismatches.", errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
